// File: rtl/core/mvdc_pkg.sv
// ----------------------------------------------------------------------------
// mvdc_pkg
// Shared types, codes and reset values of the metered valve dispense
// controller.
// ----------------------------------------------------------------------------
package mvdc_pkg;

  localparam int unsigned VOL_W   = 16;
  localparam int unsigned PULSE_W = 8;
  localparam int unsigned MLPP_W  = 4;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_TDATA_W   = 24;
  localparam int unsigned OUT_TDATA_W  = 24;
  localparam int unsigned OUT_TUSER_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 3'd0,
    CMD_QUERY = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_TICK  = 3'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_START    = 3'd0,
    KIND_PROGRESS = 3'd1,
    KIND_STOP     = 3'd2,
    KIND_NO_WATER = 3'd3,
    KIND_UNKNOWN  = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_VOLUME  = 3'd0,
    REG_MAX_VOLUME  = 3'd1,
    REG_MIN_FLOW    = 3'd2,
    REG_LF_TIMEOUT  = 3'd3,
    REG_ML_PER_PULSE = 3'd4
  } reg_idx_t;

  localparam logic [VOL_W-1:0]   RST_MIN_VOLUME   = 16'd25;
  localparam logic [VOL_W-1:0]   RST_MAX_VOLUME   = 16'd300;
  localparam logic [PULSE_W-1:0] RST_MIN_FLOW     = 8'd17;
  localparam logic [PULSE_W-1:0] RST_LF_TIMEOUT   = 8'd10;
  localparam logic [MLPP_W-1:0]  RST_ML_PER_PULSE = 4'd2;

  typedef struct packed {
    logic [VOL_W-1:0]   min_volume;
    logic [VOL_W-1:0]   max_volume;
    logic [PULSE_W-1:0] min_flow_pulses;
    logic [PULSE_W-1:0] low_flow_timeout;
    logic [MLPP_W-1:0]  ml_per_pulse;
  } cfg_t;

endpackage

// File: rtl/core/mvdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// mvdc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module mvdc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mvdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mvdc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mvdc_pkg::cfg_t                cfg
);
  import mvdc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_volume       <= RST_MIN_VOLUME;
      cfg_r.max_volume       <= RST_MAX_VOLUME;
      cfg_r.min_flow_pulses  <= RST_MIN_FLOW;
      cfg_r.low_flow_timeout <= RST_LF_TIMEOUT;
      cfg_r.ml_per_pulse     <= RST_ML_PER_PULSE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_VOLUME:   cfg_r.min_volume       <= cfg_wdata;
        REG_MAX_VOLUME:   cfg_r.max_volume       <= cfg_wdata;
        REG_MIN_FLOW:     cfg_r.min_flow_pulses  <= cfg_wdata[PULSE_W-1:0];
        REG_LF_TIMEOUT:   cfg_r.low_flow_timeout <= cfg_wdata[PULSE_W-1:0];
        REG_ML_PER_PULSE: cfg_r.ml_per_pulse     <= cfg_wdata[MLPP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/mvdc_step.sv
// ----------------------------------------------------------------------------
// mvdc_step
// Input register, pour state, single-pass command logic and result register.
// ----------------------------------------------------------------------------
module mvdc_step (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mvdc_pkg::cfg_t                 cfg,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mvdc_pkg::CMD_W-1:0]     in_cmd,
  input  logic [mvdc_pkg::VOL_W-1:0]     in_req,
  input  logic [mvdc_pkg::PULSE_W-1:0]   in_pulses,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mvdc_pkg::KIND_W-1:0]    out_kind,
  output logic                           out_failed,
  output logic [mvdc_pkg::VOL_W-1:0]     out_volume,
  output logic                           out_valve
);
  import mvdc_pkg::*;

  // Input register.
  logic                 in_vld_r;
  logic [CMD_W-1:0]     cmd_r;
  logic [VOL_W-1:0]     req_r;
  logic [PULSE_W-1:0]   pulses_r;

  // Pour state.
  logic                 pouring_r, pouring_nxt;
  logic                 metering_r, metering_nxt;
  logic [VOL_W-1:0]     target_r, target_nxt;
  logic [VOL_W-1:0]     volume_r, volume_nxt;
  logic [PULSE_W-1:0]   lf_ticks_r, lf_ticks_nxt;

  // Result register.
  logic                 out_vld_r;
  kind_t                kind_r, kind_nxt;
  logic                 failed_r, failed_nxt;
  logic                 emit;

  logic                          adv;
  logic [PULSE_W+MLPP_W-1:0]     added;
  logic [VOL_W:0]                sum;
  logic [VOL_W-1:0]              vol_tick;
  logic [PULSE_W-1:0]            lf_tick;
  logic                          pour_tick;

  // The held item is processed whenever the result register is free or drains.
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  assign added    = pulses_r * cfg.ml_per_pulse;
  assign sum      = {1'b0, volume_r} + {{(VOL_W+1-PULSE_W-MLPP_W){1'b0}}, added};
  assign vol_tick = sum[VOL_W] ? {VOL_W{1'b1}} : sum[VOL_W-1:0];
  assign pour_tick = pouring_r && !(vol_tick > target_r);

  always_comb begin
    if (pulses_r < cfg.min_flow_pulses) begin
      lf_tick = (lf_ticks_r == {PULSE_W{1'b1}}) ? lf_ticks_r : lf_ticks_r + 1'b1;
    end else begin
      lf_tick = '0;
    end
  end

  always_comb begin
    pouring_nxt  = pouring_r;
    metering_nxt = metering_r;
    target_nxt   = target_r;
    volume_nxt   = volume_r;
    lf_ticks_nxt = lf_ticks_r;
    emit         = 1'b1;
    kind_nxt     = KIND_UNKNOWN;
    failed_nxt   = 1'b1;
    case (cmd_r)
      CMD_START: begin
        kind_nxt = KIND_START;
        if (!(pouring_r || req_r > cfg.max_volume || req_r < cfg.min_volume)) begin
          target_nxt   = req_r;
          volume_nxt   = '0;
          lf_ticks_nxt = '0;
          metering_nxt = 1'b1;
          pouring_nxt  = 1'b1;
          failed_nxt   = 1'b0;
        end
      end
      CMD_QUERY: begin
        kind_nxt   = KIND_PROGRESS;
        failed_nxt = 1'b0;
      end
      CMD_STOP: begin
        kind_nxt = KIND_STOP;
        if (pouring_r) begin
          pouring_nxt = 1'b0;
          failed_nxt  = 1'b0;
        end
      end
      CMD_TICK: begin
        kind_nxt = KIND_NO_WATER;
        emit     = 1'b0;
        if (metering_r) begin
          volume_nxt   = vol_tick;
          lf_ticks_nxt = lf_tick;
          pouring_nxt  = pour_tick;
          if (lf_tick > cfg.low_flow_timeout) begin
            metering_nxt = 1'b0;
            pouring_nxt  = 1'b0;
            // A pour still running at timeout is aborted and reported.
            emit         = pour_tick;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      pouring_r  <= 1'b0;
      metering_r <= 1'b0;
      target_r   <= '0;
      volume_r   <= '0;
      lf_ticks_r <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r  <= emit;
        pouring_r  <= pouring_nxt;
        metering_r <= metering_nxt;
        target_r   <= target_nxt;
        volume_r   <= volume_nxt;
        lf_ticks_r <= lf_ticks_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r    <= in_cmd;
      req_r    <= in_req;
      pulses_r <= in_pulses;
    end
    if (adv && emit) begin
      kind_r     <= kind_nxt;
      failed_r   <= failed_nxt;
      out_volume <= volume_nxt;
      out_valve  <= pouring_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_kind   = kind_r;
  assign out_failed = failed_r;

endmodule

// File: rtl/core/metered_valve_dispense_controller.sv
// ----------------------------------------------------------------------------
// metered_valve_dispense_controller
// Valve control for a metered pour driven by start, query, stop and tick items.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the in_ stream. in_tuser carries the command
// (start, query, stop, tick); in_tdata carries the requested volume for a
// start and the meter pulse count for a tick. Each start, query, stop or
// unknown command yields one reply item on the out_ stream; a tick yields a
// reply only when a running pour is aborted for lack of water.
// Timing: an accepted item is held in an input register and evaluated in one
// pass of compare-and-add logic into the result register, from which its
// reply is offered on out_tvalid. One item can be accepted in every cycle
// while the result register is free or drains; the pour state takes one
// update per accepted item.
// Reset (rst_n low at a clock edge) closes the valve, stops metering, clears
// the volume and low-flow count and loads the default configuration.
// When the receiver stalls, the reply waits in the result register and the
// one item behind it waits in the input register; in_tready then drops until
// out_tready returns. Configuration writes are taken at any edge with cfg_we
// high and should only be issued while no item is in flight.
// ----------------------------------------------------------------------------
module metered_valve_dispense_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mvdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mvdc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: requested_volume[15:0], pulse_count[23:16].
  input  logic [mvdc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Fields from bit 0: command[2:0].
  input  logic [mvdc_pkg::CMD_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Fields from bit 0: dispensed_volume[15:0], valve_open[16], zero fill.
  output logic [mvdc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Fields from bit 0: reply_kind[2:0], failed[3].
  output logic [mvdc_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import mvdc_pkg::*;

  cfg_t              cfg;
  logic [KIND_W-1:0] kind;
  logic              failed;
  logic [VOL_W-1:0]  volume;
  logic              valve;

  // Register file holding the volume window, flow threshold, low-flow timeout and meter scale.
  mvdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Command evaluation and pour state.
  mvdc_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .in_req     (in_tdata[VOL_W-1:0]),
    .in_pulses  (in_tdata[VOL_W+PULSE_W-1:VOL_W]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_kind   (kind),
    .out_failed (failed),
    .out_volume (volume),
    .out_valve  (valve)
  );

  // Pack the reply fields; the unused tdata bits are tied to zero.
  assign out_tdata = {{(OUT_TDATA_W-VOL_W-1){1'b0}}, valve, volume};
  assign out_tuser = {failed, kind};

endmodule

// File: bench/dispense_reply_checker.sv
// ----------------------------------------------------------------------------
// Dispense reply checker
// Watches the register port and both streams of the valve controller. It
// keeps its own copy of the pour state and the limits, predicts the reply of
// every accepted item, and compares the replies that leave the block in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dispense_reply_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mvdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mvdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [mvdc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [mvdc_pkg::CMD_W-1:0]       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [mvdc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [mvdc_pkg::OUT_TUSER_W-1:0] out_tuser,
  output int unsigned                      mismatches,
  output int unsigned                      replies_waiting,
  output int unsigned                      replies_seen
);
  import mvdc_pkg::*;

  localparam logic [VOL_W-1:0]   VOL_FULL   = {VOL_W{1'b1}};
  localparam logic [PULSE_W-1:0] COUNT_FULL = {PULSE_W{1'b1}};
  localparam int unsigned        REPORT_MAX = 10;

  typedef struct packed {
    kind_t            kind;
    logic             failed;
    logic [VOL_W-1:0] volume;
    logic             valve;
  } reply_t;

  // Limits as last written over the register port.
  logic [VOL_W-1:0]   lim_min_vol;
  logic [VOL_W-1:0]   lim_max_vol;
  logic [PULSE_W-1:0] lim_min_flow;
  logic [PULSE_W-1:0] lim_timeout;
  logic [MLPP_W-1:0]  lim_mlpp;

  // Pour state.
  logic               pour_on;
  logic               meter_on;
  logic [VOL_W-1:0]   goal_ml;
  logic [VOL_W-1:0]   poured_ml;
  logic [PULSE_W-1:0] dry_ticks;

  reply_t      pending_replies[$];
  int unsigned errors;
  int unsigned seen;

  function automatic reply_t pour_reply(input kind_t kind, input logic failed);
    reply_t r;
    r.kind   = kind;
    r.failed = failed;
    r.volume = poured_ml;
    r.valve  = pour_on;
    return r;
  endfunction

  // Applies one item to the pour state; returns 1 when the item has a reply.
  function automatic bit advance_pour(input logic [CMD_W-1:0] cmd,
                                      input logic [VOL_W-1:0] req,
                                      input logic [PULSE_W-1:0] pulses,
                                      output reply_t r);
    int unsigned total;
    r = '0;
    case (cmd)
      CMD_START: begin
        if (pour_on || req > lim_max_vol || req < lim_min_vol) begin
          r = pour_reply(KIND_START, 1'b1);
          return 1'b1;
        end
        goal_ml   = req;
        poured_ml = '0;
        dry_ticks = '0;
        meter_on  = 1'b1;
        pour_on   = 1'b1;
        r = pour_reply(KIND_START, 1'b0);
        return 1'b1;
      end
      CMD_QUERY: begin
        r = pour_reply(KIND_PROGRESS, 1'b0);
        return 1'b1;
      end
      CMD_STOP: begin
        if (pour_on) begin
          pour_on = 1'b0;
          r = pour_reply(KIND_STOP, 1'b0);
        end else begin
          r = pour_reply(KIND_STOP, 1'b1);
        end
        return 1'b1;
      end
      CMD_TICK: begin
        if (!meter_on) return 1'b0;
        total = poured_ml + pulses * lim_mlpp;
        poured_ml = (total > VOL_FULL) ? VOL_FULL : VOL_W'(total);
        if (pour_on && poured_ml > goal_ml) pour_on = 1'b0;
        if (pulses < lim_min_flow) begin
          if (dry_ticks != COUNT_FULL) dry_ticks = dry_ticks + 1'b1;
        end else begin
          dry_ticks = '0;
        end
        if (dry_ticks > lim_timeout) begin
          meter_on = 1'b0;
          if (pour_on) begin
            pour_on = 1'b0;
            r = pour_reply(KIND_NO_WATER, 1'b1);
            return 1'b1;
          end
        end
        return 1'b0;
      end
      default: begin
        r = pour_reply(KIND_UNKNOWN, 1'b1);
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    reply_t got;
    reply_t want;
    reply_t fresh;
    if (!rst_n) begin
      lim_min_vol  = RST_MIN_VOLUME;
      lim_max_vol  = RST_MAX_VOLUME;
      lim_min_flow = RST_MIN_FLOW;
      lim_timeout  = RST_LF_TIMEOUT;
      lim_mlpp     = RST_ML_PER_PULSE;
      pour_on      = 1'b0;
      meter_on     = 1'b0;
      goal_ml      = '0;
      poured_ml    = '0;
      dry_ticks    = '0;
      pending_replies.delete();
      errors = 0;
      seen   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_VOLUME:   lim_min_vol  = cfg_wdata[VOL_W-1:0];
          REG_MAX_VOLUME:   lim_max_vol  = cfg_wdata[VOL_W-1:0];
          REG_MIN_FLOW:     lim_min_flow = cfg_wdata[PULSE_W-1:0];
          REG_LF_TIMEOUT:   lim_timeout  = cfg_wdata[PULSE_W-1:0];
          REG_ML_PER_PULSE: lim_mlpp     = cfg_wdata[MLPP_W-1:0];
          default: ;
        endcase
      end

      // A reply always belongs to an item accepted at an earlier edge, so it
      // is checked before this edge's item is predicted.
      if (out_tvalid && out_tready) begin
        got.kind   = kind_t'(out_tuser[KIND_W-1:0]);
        got.failed = out_tuser[KIND_W];
        got.volume = out_tdata[VOL_W-1:0];
        got.valve  = out_tdata[VOL_W];
        seen++;
        if (pending_replies.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: unexpected reply kind %0d failed %0d volume %0d valve %0d",
                     $realtime, got.kind, got.failed, got.volume, got.valve);
        end else begin
          want = pending_replies.pop_front();
          if (got.kind != want.kind || got.failed != want.failed ||
              got.volume != want.volume || got.valve != want.valve) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display({"%0t: reply mismatch: expected kind %0d failed %0d ",
                        "volume %0d valve %0d, got kind %0d failed %0d ",
                        "volume %0d valve %0d"},
                       $realtime, want.kind, want.failed, want.volume, want.valve,
                       got.kind, got.failed, got.volume, got.valve);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        if (advance_pour(in_tuser, in_tdata[VOL_W-1:0], in_tdata[VOL_W +: PULSE_W],
                         fresh))
          pending_replies.push_back(fresh);
      end
    end
    mismatches      <= errors;
    replies_waiting <= pending_replies.size();
    replies_seen    <= seen;
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Valve controller testbench
// Drives start, query, stop, tick and unknown items into the dispense
// controller under six register settings, with random gaps on both streams
// and one long output stall. A separate checker predicts and compares every
// reply; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mvdc_pkg::*;

  // Commands 4 to 7 have no meaning; the block must answer them with an error.
  localparam logic [CMD_W-1:0]     CMD_FIRST_UNKNOWN = 3'd4;
  // An index past the last register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED        = 3'd6;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 4000;
  localparam int unsigned DRY_SPELL_MAX = 20;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // Fields from bit 0: requested_volume[15:0], pulse_count[23:16].
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  // Fields from bit 0: command[2:0].
  logic [CMD_W-1:0]       in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // Fields from bit 0: dispensed_volume[15:0], valve_open[16], zero fill.
  logic [OUT_TDATA_W-1:0] out_tdata;
  // Fields from bit 0: reply_kind[2:0], failed[3].
  logic [OUT_TUSER_W-1:0] out_tuser;

  int unsigned mismatches;
  int unsigned replies_waiting;
  int unsigned replies_seen;

  // Shared between the stimulus and the receiver. Both are written with
  // nonblocking assignments, so the receiver reads them after the write edge.
  bit          calm          = 1'b0;
  int unsigned hold_requests = 0;

  // Stimulus-only bookkeeping: the limits in force, used to aim the random
  // start volumes and tick pulse counts at the interesting ranges.
  bit          gaps_on = 1'b1;
  int unsigned items_sent = 0;
  int unsigned cur_min_vol, cur_max_vol, cur_flow, cur_timeout, cur_mlpp;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  metered_valve_dispense_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  dispense_reply_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .mismatches      (mismatches),
    .replies_waiting (replies_waiting),
    .replies_seen    (replies_seen)
  );

  // Offers one item, returns at the edge that accepts it or after a gap
  // behind it. If the next item follows at once, in_tvalid stays high and
  // is lowered only for a gap, so it never gets two assignments per step.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VOL_W-1:0] req,
                           input logic [PULSE_W-1:0] pulses);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {pulses, req};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Waits until every predicted reply has come back or DRAIN_LIMIT runs out,
  // then lets the block settle, since a tick still in flight may have no reply.
  task automatic settle();
    int unsigned waited;
    in_tvalid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (replies_waiting != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Writes all five registers. The narrow ones get junk in the unused upper
  // bits of the write data, which the block has to drop.
  task automatic load_limits(input int unsigned min_vol, input int unsigned max_vol,
                             input int unsigned flow, input int unsigned timeout,
                             input int unsigned mlpp);
    write_reg(REG_MIN_VOLUME, VOL_W'(min_vol));
    write_reg(REG_MAX_VOLUME, VOL_W'(max_vol));
    write_reg(REG_MIN_FLOW, {PULSE_W'($urandom), PULSE_W'(flow)});
    write_reg(REG_LF_TIMEOUT, {PULSE_W'($urandom), PULSE_W'(timeout)});
    write_reg(REG_ML_PER_PULSE, {(CFG_DATA_W-MLPP_W)'($urandom), MLPP_W'(mlpp)});
    cfg_we <= 1'b0;
    cur_min_vol = min_vol;
    cur_max_vol = max_vol;
    cur_flow    = flow;
    cur_timeout = timeout;
    cur_mlpp    = mlpp;
  endtask

  // Random traffic shaped like real pours: starts aimed inside the volume
  // window, ticks split between good and low flow, and now and then a run of
  // low-flow ticks long enough to trip a timeout up to DRY_SPELL_MAX. Queries,
  // stops, starts of any volume and unknown commands are mixed in as noise.
  task automatic pour_traffic(input int unsigned count);
    int unsigned pick;
    int unsigned dry_left;
    logic [PULSE_W-1:0] low_pulses;
    logic [PULSE_W-1:0] good_pulses;
    dry_left = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (cur_flow == 0) low_pulses = '0;
      else low_pulses = PULSE_W'($urandom_range(0, cur_flow - 1));
      good_pulses = PULSE_W'($urandom_range(cur_flow, 255));
      pick = $urandom_range(0, 99);
      if (dry_left != 0) begin
        send_item(CMD_TICK, VOL_W'($urandom), low_pulses);
        dry_left--;
      end else if (pick < 14) begin
        send_item(CMD_START, VOL_W'($urandom_range(cur_min_vol, cur_max_vol)),
                  PULSE_W'($urandom));
      end else if (pick < 19) begin
        send_item(CMD_START, VOL_W'($urandom), PULSE_W'($urandom));
      end else if (pick < 44) begin
        send_item(CMD_TICK, VOL_W'($urandom), good_pulses);
      end else if (pick < 56) begin
        send_item(CMD_TICK, VOL_W'($urandom), low_pulses);
      end else if (pick < 62) begin
        send_item(CMD_TICK, VOL_W'($urandom), PULSE_W'($urandom));
      end else if (pick < 66) begin
        dry_left = (cur_timeout + 2 > DRY_SPELL_MAX) ? DRY_SPELL_MAX : cur_timeout + 2;
        send_item(CMD_TICK, VOL_W'($urandom), low_pulses);
      end else if (pick < 78) begin
        send_item(CMD_QUERY, VOL_W'($urandom), PULSE_W'($urandom));
      end else if (pick < 89) begin
        send_item(CMD_STOP, VOL_W'($urandom), PULSE_W'($urandom));
      end else begin
        send_item(CMD_FIRST_UNKNOWN + CMD_W'($urandom_range(0, 3)),
                  VOL_W'($urandom), PULSE_W'($urandom));
      end
    end
  endtask

  // Receiver: random stalls, occasional long ready stretches, and on request
  // one long hold counted here so the block backs up and drops in_tready.
  // Once calm is set it stays ready.
  initial begin : receiver
    int unsigned holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_served++;
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 19) == 0)
          repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cur_min_vol = RST_MIN_VOLUME;
    cur_max_vol = RST_MAX_VOLUME;
    cur_flow    = RST_MIN_FLOW;
    cur_timeout = RST_LF_TIMEOUT;
    cur_mlpp    = RST_ML_PER_PULSE;

    // Reset limits. A tick before any start is ignored; starts just outside
    // the window are refused, the lower edge is taken, and a second start
    // during the pour is refused. A big tick then overshoots the target and
    // closes the valve, so the following stop finds no pour.
    send_item(CMD_TICK, 16'h0000, 8'd200);
    send_item(CMD_START, 16'd24, 8'h00);
    send_item(CMD_START, 16'd301, 8'hFF);
    send_item(CMD_START, 16'd25, 8'h00);
    send_item(CMD_START, 16'd100, 8'h00);
    send_item(CMD_TICK, 16'hFFFF, 8'd5);
    send_item(CMD_QUERY, 16'h0000, 8'h00);
    send_item(CMD_TICK, 16'h0000, 8'd255);
    send_item(CMD_STOP, 16'hFFFF, 8'hFF);
    for (int k = 0; k < 4; k++)
      send_item(CMD_FIRST_UNKNOWN + CMD_W'(k), VOL_W'($urandom), PULSE_W'($urandom));
    send_item(CMD_START, 16'd300, 8'h00);
    send_item(CMD_STOP, 16'h0000, 8'h00);
    send_item(CMD_START, 16'hFFFF, 8'hFF);
    send_item(CMD_START, 16'h0000, 8'h00);
    pour_traffic(150);
    settle();

    // Widest window, zero timeout and the largest volume per pulse. A single
    // low tick aborts a pour with no water; after a completed pour it stops
    // metering without a reply, and the next tick is ignored. A full-size pour
    // saturates the volume at its maximum, which never exceeds the target.
    load_limits(0, 65535, 255, 0, 15);
    send_item(CMD_START, 16'd0, 8'h00);
    send_item(CMD_TICK, 16'h0000, 8'd0);
    send_item(CMD_START, 16'd10, 8'h00);
    send_item(CMD_TICK, 16'h0000, 8'd255);
    send_item(CMD_TICK, 16'h0000, 8'd0);
    send_item(CMD_TICK, 16'h0000, 8'd0);
    send_item(CMD_QUERY, 16'h0000, 8'h00);
    send_item(CMD_START, 16'hFFFF, 8'h00);
    repeat (18) send_item(CMD_TICK, 16'h0000, 8'd255);
    send_item(CMD_QUERY, 16'h0000, 8'h00);
    send_item(CMD_TICK, 16'h0000, 8'd254);
    pour_traffic(100);
    settle();

    // Minimum above maximum: every start is refused. The stray write to an
    // index past the register list must leave the limits alone.
    write_reg(REG_UNUSED, 16'hFFFF);
    load_limits(100, 50, 0, 3, 9);
    pour_traffic(60);
    settle();

    // Timeout at its top value: the low-flow count saturates and never
    // stops metering.
    load_limits(10, 2000, 40, 255, 1);
    pour_traffic(180);
    settle();

    // No volume per pulse: ticks add nothing, so pours end only by stop or
    // by running dry.
    load_limits(1, 500, 8, 3, 0);
    pour_traffic(90);
    settle();

    // Ordinary limits. First the receiver holds off while queries keep
    // coming back to back, which fills the block and stalls its input.
    load_limits(30, 400, 20, 5, 7);
    hold_requests <= hold_requests + 1;
    gaps_on = 1'b0;
    repeat (30) send_item(CMD_QUERY, VOL_W'($urandom), PULSE_W'($urandom));
    gaps_on = 1'b1;
    pour_traffic(200);
    // Last stretch at full rate on both sides.
    calm <= 1'b1;
    gaps_on = 1'b0;
    pour_traffic(150);
    settle();

    $display("Sent %0d items under six register settings; %0d replies checked.",
             items_sent, replies_seen);
    if (mismatches == 0 && replies_waiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (replies_waiting != 0)
        $display("%0d expected replies never arrived", replies_waiting);
      $display("%0d replies did not match", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Ends a run that does not finish, with a wide margin over the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("Run did not finish in time");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mvdc_pkg.sv
rtl/core/mvdc_cfg_regs.sv
rtl/core/mvdc_step.sv
rtl/core/metered_valve_dispense_controller.sv
bench/dispense_reply_checker.sv
bench/testbench.sv
